/* src/ihp_pkg.sv */
`timescale 1ns / 1ps

package ihp_pkg;

  // command codes
  localparam logic [2:0] CMD_INSERT   = 3'd0;
  localparam logic [2:0] CMD_REM_TOP  = 3'd1;
  localparam logic [2:0] CMD_REM_POS  = 3'd2;
  localparam logic [2:0] CMD_CHG_KEY  = 3'd3;
  localparam logic [2:0] CMD_QUERY    = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_DUP       = 3'd3;
  localparam logic [2:0] ST_ABSENT    = 3'd4;
  localparam logic [2:0] ST_BAD_POS   = 3'd5;
  localparam logic [2:0] ST_BAD_CMD   = 3'd6;

  // one result word
  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         rid;
    logic signed [31:0] rkey;
    logic               rvalid;
    logic               present;
    logic [8:0]         count;
    logic [7:0]         top_id;
    logic signed [31:0] top_key;
    logic               empty;
  } res_t;

endpackage

/* src/ihp_ram.sv */
`timescale 1ns / 1ps

module ihp_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/ihp_ctrl.sv */
`timescale 1ns / 1ps

module ihp_ctrl
  import ihp_pkg::*;
#(
  parameter int NUM_IDS  = 256,
  parameter int KEY_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_cmd,
  input  logic [7:0]                in_elem_id,
  input  logic signed [31:0]        in_key_value,
  input  logic [7:0]                in_position,
  output logic                      res_vld,
  input  logic                      res_rdy,
  output res_t                      res,
  // slot memory
  output logic                      slot_we,
  output logic [$clog2(NUM_IDS)-1:0] slot_wa,
  output logic [$clog2(NUM_IDS)-1:0] slot_wd,
  output logic                      slot_re,
  output logic [$clog2(NUM_IDS)-1:0] slot_ra,
  input  logic [$clog2(NUM_IDS)-1:0] slot_rd,
  // id memory: held, position, key
  output logic                      idm_we,
  output logic [$clog2(NUM_IDS)-1:0] idm_wa,
  output logic [$clog2(NUM_IDS)+KEY_BITS:0] idm_wd,
  output logic                      idm_re,
  output logic [$clog2(NUM_IDS)-1:0] idm_ra,
  input  logic [$clog2(NUM_IDS)+KEY_BITS:0] idm_rd
);

  localparam int IDW = $clog2(NUM_IDS);
  localparam int CW  = $clog2(NUM_IDS + 1);
  localparam int XW  = IDW + 2;
  localparam int IW  = 1 + IDW + KEY_BITS;

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_INS   = 5'd2;
  localparam logic [4:0] S_UP    = 5'd3;
  localparam logic [4:0] S_UP_B  = 5'd4;
  localparam logic [4:0] S_UP_C  = 5'd5;
  localparam logic [4:0] S_PLACE = 5'd6;
  localparam logic [4:0] S_PRES  = 5'd7;
  localparam logic [4:0] S_FIN   = 5'd8;
  localparam logic [4:0] S_DN    = 5'd9;
  localparam logic [4:0] S_DN_B  = 5'd10;
  localparam logic [4:0] S_DN_C  = 5'd11;
  localparam logic [4:0] S_DN_D  = 5'd12;
  localparam logic [4:0] S_DN_E  = 5'd13;
  localparam logic [4:0] S_DN_F  = 5'd14;
  localparam logic [4:0] S_RM_A  = 5'd15;
  localparam logic [4:0] S_RM_B  = 5'd16;
  localparam logic [4:0] S_RM_C  = 5'd17;
  localparam logic [4:0] S_RM_D  = 5'd18;
  localparam logic [4:0] S_CHG   = 5'd19;
  localparam logic [4:0] S_Q_A   = 5'd20;
  localparam logic [4:0] S_Q_B   = 5'd21;

  logic [4:0]                state_r, state_nxt;
  logic [IDW-1:0]            clr_r, clr_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [IDW-1:0]            id_r, id_nxt;
  logic                      idok_r, idok_nxt;
  logic signed [KEY_BITS-1:0] key_r, key_nxt;
  logic [IDW-1:0]            hole_r, hole_nxt;
  logic [IDW-1:0]            m_id_r, m_id_nxt;
  logic signed [KEY_BITS-1:0] m_key_r, m_key_nxt;
  logic [IDW-1:0]            par_id_r, par_id_nxt;
  logic                      up_dn_r, up_dn_nxt;
  logic [IDW-1:0]            cand_id_r, cand_id_nxt;
  logic [IDW-1:0]            best_id_r, best_id_nxt;
  logic signed [KEY_BITS-1:0] best_key_r, best_key_nxt;
  logic [IDW-1:0]            best_idx_r, best_idx_nxt;
  logic                      best_mv_r, best_mv_nxt;
  logic [IDW-1:0]            gone_r, gone_nxt;
  logic signed [KEY_BITS-1:0] gkey_r, gkey_nxt;
  logic [IDW-1:0]            lid_r, lid_nxt;
  logic [2:0]                st_r, st_nxt;
  logic [IDW-1:0]            oid_r, oid_nxt;
  logic signed [KEY_BITS-1:0] okey_r, okey_nxt;
  logic                      ovld_r, ovld_nxt;
  logic [IDW-1:0]            top_id_r, top_id_nxt;
  logic signed [KEY_BITS-1:0] top_key_r, top_key_nxt;

  logic                      rd_held;
  logic [IDW-1:0]            rd_pos;
  logic signed [KEY_BITS-1:0] rd_key;
  logic                      in_idok;
  logic [IDW-1:0]            in_idx;
  logic [IDW-1:0]            rem_slot;
  logic [IDW-1:0]            parent;
  logic [XW-1:0]             lchild, rchild, cnt_x;
  logic [IDW-1:0]            last;

  assign rd_held  = idm_rd[IW-1];
  assign rd_pos   = idm_rd[IW-2 -: IDW];
  assign rd_key   = idm_rd[KEY_BITS-1:0];
  assign in_idok  = 32'(in_elem_id) < 32'(NUM_IDS);
  assign in_idx   = IDW'({24'd0, in_elem_id});
  assign rem_slot = (in_cmd == CMD_REM_TOP) ? '0 : IDW'({24'd0, in_position});
  assign parent   = IDW'(hole_r - 1'b1) >> 1;
  assign lchild   = XW'({hole_r, 1'b1});
  assign rchild   = lchild + 1'b1;
  assign cnt_x    = XW'(cnt_r);
  assign last     = IDW'(cnt_r - 1'b1);
  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
    end
    id_r       <= id_nxt;
    idok_r     <= idok_nxt;
    key_r      <= key_nxt;
    hole_r     <= hole_nxt;
    m_id_r     <= m_id_nxt;
    m_key_r    <= m_key_nxt;
    par_id_r   <= par_id_nxt;
    up_dn_r    <= up_dn_nxt;
    cand_id_r  <= cand_id_nxt;
    best_id_r  <= best_id_nxt;
    best_key_r <= best_key_nxt;
    best_idx_r <= best_idx_nxt;
    best_mv_r  <= best_mv_nxt;
    gone_r     <= gone_nxt;
    gkey_r     <= gkey_nxt;
    lid_r      <= lid_nxt;
    st_r       <= st_nxt;
    oid_r      <= oid_nxt;
    okey_r     <= okey_nxt;
    ovld_r     <= ovld_nxt;
    top_id_r   <= top_id_nxt;
    top_key_r  <= top_key_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    cnt_nxt      = cnt_r;
    id_nxt       = id_r;
    idok_nxt     = idok_r;
    key_nxt      = key_r;
    hole_nxt     = hole_r;
    m_id_nxt     = m_id_r;
    m_key_nxt    = m_key_r;
    par_id_nxt   = par_id_r;
    up_dn_nxt    = up_dn_r;
    cand_id_nxt  = cand_id_r;
    best_id_nxt  = best_id_r;
    best_key_nxt = best_key_r;
    best_idx_nxt = best_idx_r;
    best_mv_nxt  = best_mv_r;
    gone_nxt     = gone_r;
    gkey_nxt     = gkey_r;
    lid_nxt      = lid_r;
    st_nxt       = st_r;
    oid_nxt      = oid_r;
    okey_nxt     = okey_r;
    ovld_nxt     = ovld_r;
    top_id_nxt   = top_id_r;
    top_key_nxt  = top_key_r;
    slot_we = 1'b0;
    slot_wa = hole_r;
    slot_wd = m_id_r;
    slot_re = 1'b0;
    slot_ra = hole_r;
    idm_we  = 1'b0;
    idm_wa  = m_id_r;
    idm_wd  = {1'b1, hole_r, m_key_r};
    idm_re  = 1'b0;
    idm_ra  = id_r;
    res_vld = 1'b0;

    unique case (state_r)
      S_CLR: begin
        idm_we  = 1'b1;
        idm_wa  = clr_r;
        idm_wd  = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IDW'(NUM_IDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          id_nxt   = in_idx;
          idok_nxt = in_idok;
          key_nxt  = KEY_BITS'(in_key_value);
          st_nxt   = ST_OK;
          ovld_nxt = 1'b0;
          up_dn_nxt = 1'b0;
          state_nxt = S_PRES;
          priority case (in_cmd)
            CMD_INSERT: begin
              if (!in_idok) begin
                st_nxt = ST_BAD_POS;
              end else if (cnt_r == CW'(NUM_IDS)) begin
                st_nxt = ST_FULL;
              end else begin
                idm_re    = 1'b1;
                idm_ra    = in_idx;
                state_nxt = S_INS;
              end
            end
            CMD_REM_TOP, CMD_REM_POS: begin
              if (cnt_r == '0) begin
                st_nxt = ST_EMPTY;
              end else if (32'(rem_slot) >= 32'(cnt_r) ||
                           32'(in_position) >= 32'(cnt_r) && in_cmd == CMD_REM_POS) begin
                st_nxt = ST_BAD_POS;
              end else begin
                hole_nxt  = rem_slot;
                slot_re   = 1'b1;
                slot_ra   = rem_slot;
                state_nxt = S_RM_A;
              end
            end
            CMD_CHG_KEY: begin
              if (!in_idok) begin
                st_nxt = ST_ABSENT;
              end else begin
                idm_re    = 1'b1;
                idm_ra    = in_idx;
                state_nxt = S_CHG;
              end
            end
            CMD_QUERY: begin
              if (32'(in_position) >= 32'(cnt_r)) begin
                st_nxt = ST_BAD_POS;
              end else begin
                slot_re   = 1'b1;
                slot_ra   = IDW'({24'd0, in_position});
                state_nxt = S_Q_A;
              end
            end
            default: st_nxt = ST_BAD_CMD;
          endcase
        end
      end
      S_INS: begin
        if (rd_held) begin
          st_nxt    = ST_DUP;
          state_nxt = S_PRES;
        end else begin
          m_id_nxt  = id_r;
          m_key_nxt = key_r;
          hole_nxt  = IDW'(cnt_r);
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_UP;
        end
      end
      S_UP: begin
        if (hole_r == '0) begin
          state_nxt = S_PLACE;
        end else begin
          slot_re   = 1'b1;
          slot_ra   = parent;
          state_nxt = S_UP_B;
        end
      end
      S_UP_B: begin
        par_id_nxt = slot_rd;
        idm_re     = 1'b1;
        idm_ra     = slot_rd;
        state_nxt  = S_UP_C;
      end
      S_UP_C: begin
        if (m_key_r < rd_key) begin
          // parent moves down into the hole
          slot_we   = 1'b1;
          slot_wa   = hole_r;
          slot_wd   = par_id_r;
          idm_we    = 1'b1;
          idm_wa    = par_id_r;
          idm_wd    = {1'b1, hole_r, rd_key};
          hole_nxt  = parent;
          up_dn_nxt = 1'b0;
          state_nxt = S_UP;
        end else if (up_dn_r) begin
          up_dn_nxt = 1'b0;
          state_nxt = S_DN;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        slot_we = 1'b1;
        idm_we  = 1'b1;
        if (hole_r == '0) begin
          top_id_nxt  = m_id_r;
          top_key_nxt = m_key_r;
        end
        state_nxt = S_PRES;
      end
      S_PRES: begin
        idm_re    = 1'b1;
        idm_ra    = id_r;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        res_vld = 1'b1;
        if (res_rdy) begin
          state_nxt = S_IDLE;
        end
      end
      S_DN: begin
        if (lchild >= cnt_x) begin
          state_nxt = S_PLACE;
        end else begin
          best_mv_nxt  = 1'b0;
          best_key_nxt = m_key_r;
          slot_re      = 1'b1;
          slot_ra      = IDW'(lchild);
          state_nxt    = S_DN_B;
        end
      end
      S_DN_B: begin
        cand_id_nxt = slot_rd;
        idm_re      = 1'b1;
        idm_ra      = slot_rd;
        state_nxt   = S_DN_C;
      end
      S_DN_C: begin
        if (rd_key < m_key_r) begin
          best_mv_nxt  = 1'b1;
          best_idx_nxt = IDW'(lchild);
          best_id_nxt  = cand_id_r;
          best_key_nxt = rd_key;
        end
        if (rchild < cnt_x) begin
          slot_re   = 1'b1;
          slot_ra   = IDW'(rchild);
          state_nxt = S_DN_D;
        end else begin
          state_nxt = S_DN_F;
        end
      end
      S_DN_D: begin
        cand_id_nxt = slot_rd;
        idm_re      = 1'b1;
        idm_ra      = slot_rd;
        state_nxt   = S_DN_E;
      end
      S_DN_E: begin
        if (rd_key < best_key_r) begin
          best_mv_nxt  = 1'b1;
          best_idx_nxt = IDW'(rchild);
          best_id_nxt  = cand_id_r;
          best_key_nxt = rd_key;
        end
        state_nxt = S_DN_F;
      end
      S_DN_F: begin
        if (!best_mv_r) begin
          state_nxt = S_PLACE;
        end else begin
          // smaller child moves up into the hole
          slot_we = 1'b1;
          slot_wa = hole_r;
          slot_wd = best_id_r;
          idm_we  = 1'b1;
          idm_wa  = best_id_r;
          idm_wd  = {1'b1, hole_r, best_key_r};
          if (hole_r == '0) begin
            top_id_nxt  = best_id_r;
            top_key_nxt = best_key_r;
          end
          hole_nxt  = best_idx_r;
          state_nxt = S_DN;
        end
      end
      S_RM_A: begin
        gone_nxt  = slot_rd;
        idm_re    = 1'b1;
        idm_ra    = slot_rd;
        state_nxt = S_RM_B;
      end
      S_RM_B: begin
        gkey_nxt  = rd_key;
        slot_re   = 1'b1;
        slot_ra   = last;
        state_nxt = S_RM_C;
      end
      S_RM_C: begin
        lid_nxt   = slot_rd;
        idm_re    = 1'b1;
        idm_ra    = slot_rd;
        state_nxt = S_RM_D;
      end
      S_RM_D: begin
        idm_we   = 1'b1;
        idm_wa   = gone_r;
        idm_wd   = {1'b0, hole_r, gkey_r};
        oid_nxt  = gone_r;
        okey_nxt = gkey_r;
        ovld_nxt = 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
        m_id_nxt  = lid_r;
        m_key_nxt = rd_key;
        if (hole_r == last) begin
          state_nxt = S_PRES;
        end else if (rd_key < gkey_r) begin
          state_nxt = S_UP;
        end else if (gkey_r < rd_key) begin
          state_nxt = S_DN;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_CHG: begin
        if (!rd_held) begin
          st_nxt    = ST_ABSENT;
          state_nxt = S_PRES;
        end else begin
          hole_nxt  = rd_pos;
          m_id_nxt  = id_r;
          m_key_nxt = key_r;
          if (rd_pos == '0) begin
            state_nxt = S_DN;
          end else begin
            up_dn_nxt = 1'b1;
            state_nxt = S_UP;
          end
        end
      end
      S_Q_A: begin
        oid_nxt   = slot_rd;
        idm_re    = 1'b1;
        idm_ra    = slot_rd;
        state_nxt = S_Q_B;
      end
      S_Q_B: begin
        okey_nxt  = rd_key;
        ovld_nxt  = 1'b1;
        state_nxt = S_PRES;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    res.status  = st_r;
    res.rvalid  = ovld_r;
    res.rid     = ovld_r ? 8'(32'(oid_r)) : 8'd0;
    res.rkey    = ovld_r ? 32'(okey_r) : 32'sd0;
    res.present = idok_r & rd_held;
    res.count   = 9'(32'(cnt_r));
    res.empty   = (cnt_r == '0);
    res.top_id  = res.empty ? 8'd0 : 8'(32'(top_id_r));
    res.top_key = res.empty ? 32'sd0 : 32'(top_key_r);
  end

endmodule

/* src/indexed_min_heap_core.sv */
`timescale 1ns / 1ps

// indexed binary min-heap of element ids ordered by signed key
// input word: in_cmd (insert, remove top, remove at slot, change key, query),
//   in_elem_id, in_key_value, in_position; taken when in_valid is high and
//   in_stall is low
// result word: one per input word, in order, on out_* with out_valid/out_stall;
//   fields carry status, removed or queried item, presence of the id, count
//   and the current top
// one word at a time: in_stall stays high from the accepted word until its
//   result has moved into the output register; an insert sifts up and a
//   removal or key change sifts up or down, one tree level at a time; the
//   single-port memory accesses of the sift walk set the pace
// after reset the id table is swept clear while in_stall stays high
// a finished result sits in the output register; the core may take the next
//   word while it waits, but holds its own result until out_stall drops
module indexed_min_heap_core
  import ihp_pkg::*;
#(
  parameter int NUM_IDS  = 256,
  parameter int KEY_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_cmd,
  input  logic [7:0]         in_elem_id,
  input  logic signed [31:0] in_key_value,
  input  logic [7:0]         in_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [7:0]         out_out_id,
  output logic signed [31:0] out_out_key,
  output logic               out_out_valid,
  output logic               out_present,
  output logic [8:0]         out_count,
  output logic [7:0]         out_top_id,
  output logic signed [31:0] out_top_key,
  output logic               out_empty_res
);

  localparam int IDW = $clog2(NUM_IDS);
  localparam int IW  = 1 + IDW + KEY_BITS;

  // slot memory: id held in each heap slot
  logic           slot_we, slot_re;
  logic [IDW-1:0] slot_wa, slot_wd, slot_ra, slot_rd;
  // id memory: held flag, slot and key of each id
  logic           idm_we, idm_re;
  logic [IDW-1:0] idm_wa, idm_ra;
  logic [IW-1:0]  idm_wd, idm_rd;

  logic res_vld, res_rdy;
  res_t res;

  // output register
  logic out_valid_r, out_valid_nxt;
  res_t out_r;

  ihp_ram #(.W(IDW), .DEPTH(NUM_IDS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_wa),
    .wdata (slot_wd),
    .re    (slot_re),
    .raddr (slot_ra),
    .rdata (slot_rd)
  );

  ihp_ram #(.W(IW), .DEPTH(NUM_IDS)) u_id_ram (
    .clk   (clk),
    .we    (idm_we),
    .waddr (idm_wa),
    .wdata (idm_wd),
    .re    (idm_re),
    .raddr (idm_ra),
    .rdata (idm_rd)
  );

  ihp_ctrl #(.NUM_IDS(NUM_IDS), .KEY_BITS(KEY_BITS)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_elem_id   (in_elem_id),
    .in_key_value (in_key_value),
    .in_position  (in_position),
    .res_vld      (res_vld),
    .res_rdy      (res_rdy),
    .res          (res),
    .slot_we      (slot_we),
    .slot_wa      (slot_wa),
    .slot_wd      (slot_wd),
    .slot_re      (slot_re),
    .slot_ra      (slot_ra),
    .slot_rd      (slot_rd),
    .idm_we       (idm_we),
    .idm_wa       (idm_wa),
    .idm_wd       (idm_wd),
    .idm_re       (idm_re),
    .idm_ra       (idm_ra),
    .idm_rd       (idm_rd)
  );

  // the register frees up when empty or when its word leaves this cycle
  assign res_rdy = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_vld && res_rdy) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_vld && res_rdy) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_r.status;
  assign out_out_id    = out_r.rid;
  assign out_out_key   = out_r.rkey;
  assign out_out_valid = out_r.rvalid;
  assign out_present   = out_r.present;
  assign out_count     = out_r.count;
  assign out_top_id    = out_r.top_id;
  assign out_top_key   = out_r.top_key;
  assign out_empty_res = out_r.empty;

endmodule
